FILE: sv/cds_pkg.sv
// Shared types and character codes for the C directive stripper.
package cds_pkg;

   localparam logic [7:0] CHAR_QUOTE   = 8'h22;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_HASH    = 8'h23;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
   } rsp_type;

   typedef enum logic [6:0] {
      MODE_NORMAL     = 7'b0000001,
      MODE_STRING     = 7'b0000010,
      MODE_SLASH      = 7'b0000100,
      MODE_LINE       = 7'b0001000,
      MODE_BLOCK      = 7'b0010000,
      MODE_BLOCK_STAR = 7'b0100000,
      MODE_DIRECTIVE  = 7'b1000000
   } mode_type;

   // What one input byte produces: up to two kept bytes and the next mode.
   typedef struct packed {
      logic [1:0] count;
      logic [7:0] first_char;
      logic [7:0] second_char;
      mode_type   next_mode;
   } dec_type;

endpackage

FILE: sv/cds_decode.sv
// Scan-mode decoder: kept bytes and next mode for one input byte.
module cds_decode
   import cds_pkg::*;
(
   input  mode_type mode,
   input  req_type  item,
   output dec_type  dec
);

   logic [7:0] ch;
   logic       nrm_keep;
   mode_type   nrm_next;

   assign ch = item.in_byte;

   // Normal-text handling of the current byte.
   always_comb begin
      nrm_keep = 1'b0;
      nrm_next = MODE_NORMAL;
      if (ch == CHAR_QUOTE) begin
         nrm_keep = 1'b1;
         nrm_next = MODE_STRING;
      end else if (ch == CHAR_SLASH) begin
         nrm_next = MODE_SLASH;
      end else if (ch == CHAR_HASH) begin
         nrm_next = MODE_DIRECTIVE;
      end else begin
         nrm_keep = 1'b1;
      end
   end

   always_comb begin
      dec.count       = 2'd0;
      dec.first_char  = ch;
      dec.second_char = ch;
      dec.next_mode   = MODE_NORMAL;
      unique case (mode)
         MODE_STRING: begin
            dec.count     = 2'd1;
            dec.next_mode = (ch == CHAR_QUOTE) ? MODE_NORMAL : MODE_STRING;
         end
         MODE_SLASH: begin
            dec.first_char = CHAR_SLASH;
            if (ch == CHAR_SLASH) begin
               dec.count     = 2'd2;
               dec.next_mode = MODE_LINE;
            end else if (ch == CHAR_STAR) begin
               dec.count     = 2'd2;
               dec.next_mode = MODE_BLOCK;
            end else begin
               // Flush the held slash, then treat the byte as normal text.
               dec.count     = nrm_keep ? 2'd2 : 2'd1;
               dec.next_mode = nrm_next;
            end
         end
         MODE_LINE: begin
            dec.count     = 2'd1;
            dec.next_mode = (ch == CHAR_NEWLINE) ? MODE_NORMAL : MODE_LINE;
         end
         MODE_BLOCK: begin
            dec.count     = 2'd1;
            dec.next_mode = (ch == CHAR_STAR) ? MODE_BLOCK_STAR : MODE_BLOCK;
         end
         MODE_BLOCK_STAR: begin
            dec.count = 2'd1;
            if (ch == CHAR_SLASH) begin
               dec.next_mode = MODE_NORMAL;
            end else if (ch == CHAR_STAR) begin
               dec.next_mode = MODE_BLOCK_STAR;
            end else begin
               dec.next_mode = MODE_BLOCK;
            end
         end
         MODE_DIRECTIVE: begin
            dec.next_mode = (ch == CHAR_NEWLINE) ? MODE_NORMAL : MODE_DIRECTIVE;
         end
         default: begin
            dec.count     = nrm_keep ? 2'd1 : 2'd0;
            dec.next_mode = nrm_next;
         end
      endcase

      // End of text: flush a pending slash and return to normal text.
      if (item.end_of_text) begin
         if (dec.next_mode == MODE_SLASH) begin
            if (dec.count == 2'd0) begin
               dec.first_char = CHAR_SLASH;
               dec.count      = 2'd1;
            end else begin
               dec.second_char = CHAR_SLASH;
               dec.count       = 2'd2;
            end
         end
         dec.next_mode = MODE_NORMAL;
      end
   end

endmodule

FILE: sv/c_directive_stripper_core.sv
// Top level of the C directive stripper: input register, decoder, result pair buffer.
//
// Usage
//   req channel: one source byte per transaction (req_data.in_byte) with
//   req_data.end_of_text set on the last byte of a text. rsp channel: the
//   kept bytes in order; rsp_data.run_last marks the final kept byte caused
//   by an input byte. Bytes of a preprocessor directive ('#' up to and
//   including the newline, outside strings and comments) are dropped.
// Pipeline and throughput
//   An accepted byte is registered in the input register and decoded
//   there; once the result pair buffer is free its results are
//   registered into that buffer and offered from there. One input byte per
//   cycle is sustained while each byte yields at most one result and
//   rsp_stall stays low; a byte that yields two results (a flushed '/' plus
//   the byte) occupies the result port for both, so the input stalls while
//   the first of them is sent. The single result port sets this limit.
// Reset
//   Synchronous, active high: both stages empty, scan mode back to normal
//   text.
// Receiver stall
//   Results hold on rsp_data while rsp_stall is high. The input register
//   keeps accepting until it is full and cannot hand its byte on, and then
//   req_stall rises in the same cycle.
module c_directive_stripper_core
   import cds_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Input register
   logic     in_valid_ff, in_valid_in;
   req_type  in_item_ff;
   logic     req_take;

   // Scan mode
   mode_type mode_ff, mode_in;

   // Result pair buffer: pend_ff counts bytes still to send (0..2).
   logic [1:0] pend_ff, pend_in;
   logic [7:0] slot0_ff, slot1_ff;
   logic       rsp_take;
   logic       buf_free;
   logic       advance;

   dec_type    dec;

   cds_decode u_decode (
      .mode (mode_ff),
      .item (in_item_ff),
      .dec  (dec)
   );

   // Offer slot0 first when two bytes wait; the last byte always sits in slot1.
   assign rsp_valid         = (pend_ff != 2'd0);
   assign rsp_data.out_byte = (pend_ff == 2'd2) ? slot0_ff : slot1_ff;
   assign rsp_data.run_last = (pend_ff == 2'd1);
   assign rsp_take          = rsp_valid & ~rsp_stall;

   // Buffer can load this cycle if empty or its last byte is leaving now.
   assign buf_free  = (pend_ff == 2'd0) | ((pend_ff == 2'd1) & rsp_take);
   assign advance   = in_valid_ff & buf_free;
   assign req_stall = in_valid_ff & ~buf_free;
   assign req_take  = req_valid & ~req_stall;

   always_comb begin
      in_valid_in = req_take | (in_valid_ff & ~advance);
      mode_in     = advance ? dec.next_mode : mode_ff;
      pend_in     = pend_ff;
      if (advance) begin
         pend_in = dec.count;
      end else if (rsp_take) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_NORMAL;
         pend_ff     <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         mode_ff     <= mode_in;
         pend_ff     <= pend_in;
      end
   end

   // Payload registers: load on acceptance / advance, no reset needed.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_data;
      end
      if (advance) begin
         if (dec.count == 2'd2) begin
            slot0_ff <= dec.first_char;
            slot1_ff <= dec.second_char;
         end else begin
            slot1_ff <= dec.first_char;
         end
      end
   end

   // End of text always leaves the scanner in normal text.
   a_eot_normal: assert property (@(posedge clock) disable iff (reset)
      (advance && in_item_ff.end_of_text) |=> (mode_ff == MODE_NORMAL))
      else $error("scan mode not normal after end of text");

   // Sending the first of two bytes leaves exactly the second one.
   a_pair_second: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && pend_ff == 2'd2) |=> (rsp_valid && pend_ff == 2'd1))
      else $error("second byte of a pair lost");

   // Input only stalls while the input register holds a byte.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled with an empty input register");

   // A byte stuck in the input register stays there.
   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("held input byte changed or vanished");

endmodule
